>>> rtl/core/ped_pkg.sv
// Shared types and codes for the palette error-diffusion ditherer.
package ped_pkg;

    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_TAP     = 2'd1;
    localparam logic [1:0] OP_PIXEL   = 2'd2;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PAL_COUNT    = 3'd2;
    localparam logic [2:0] REG_TAP_COUNT    = 3'd3;
    localparam logic [2:0] REG_ERR_DIVISOR  = 3'd4;
    localparam logic [2:0] REG_STRENGTH     = 3'd5;
    localparam logic [2:0] REG_SERPENTINE   = 3'd6;

    localparam int ERR_W = 24;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic       busy;
        logic [7:0] idx;
        rgb_t       color;
    } near_res_t;

endpackage

>>> rtl/core/ped_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ped_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ped_div.sv
// Bit-serial restoring divider for the magnitude of one diffused error term.
module ped_div #(
    parameter int QW = 39
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [15:0]   divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);

    localparam int CNW = $clog2(QW + 1);

    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic [QW-1:0]  quo_reg;
    logic [15:0]    rem_reg;
    logic [15:0]    dvs_reg;
    logic [16:0]    trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNW'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[QW-2:0], fits};
            rem_reg <= fits ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/ped_near.sv
// Nearest-colour search pipeline: squared distance per entry, then running minimum.
module ped_near
    import ped_pkg::*;
#(
    parameter int VW = 25,
    parameter int F  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_idx,
    input  rgb_t                 in_color,
    input  logic signed [VW-1:0] v_r,
    input  logic signed [VW-1:0] v_g,
    input  logic signed [VW-1:0] v_b,
    output near_res_t            res
);

    localparam int SQW = 2 * VW - 2;
    localparam int SW  = 2 * VW;

    logic signed [VW-1:0]  d_r, d_g, d_b;
    logic signed [SW-1:0]  p_r, p_g, p_b;
    logic [SQW-1:0]        sq_r_reg, sq_g_reg, sq_b_reg;
    logic                  s2_valid_reg;
    logic [7:0]            s2_idx_reg;
    rgb_t                  s2_color_reg;
    logic [SW-1:0]         dist_sum;
    logic [SW-1:0]         best_d_reg;
    logic [7:0]            best_idx_reg;
    rgb_t                  best_color_reg;

    assign d_r = v_r - $signed({{(VW-8-F){1'b0}}, in_color.r, {F{1'b0}}});
    assign d_g = v_g - $signed({{(VW-8-F){1'b0}}, in_color.g, {F{1'b0}}});
    assign d_b = v_b - $signed({{(VW-8-F){1'b0}}, in_color.b, {F{1'b0}}});
    assign p_r = SW'(d_r) * SW'(d_r);
    assign p_g = SW'(d_g) * SW'(d_g);
    assign p_b = SW'(d_b) * SW'(d_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        sq_r_reg     <= p_r[SQW-1:0];
        sq_g_reg     <= p_g[SQW-1:0];
        sq_b_reg     <= p_b[SQW-1:0];
        s2_idx_reg   <= in_idx;
        s2_color_reg <= in_color;
    end

    assign dist_sum = SW'(sq_r_reg) + SW'(sq_g_reg) + SW'(sq_b_reg);

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && (s2_idx_reg == 8'd0 || dist_sum < best_d_reg)) begin
            best_d_reg     <= dist_sum;
            best_idx_reg   <= s2_idx_reg;
            best_color_reg <= s2_color_reg;
        end
    end

    assign res.busy  = s2_valid_reg;
    assign res.idx   = best_idx_reg;
    assign res.color = best_color_reg;

endmodule

>>> rtl/core/palette_error_diffusion_top.sv
// Top level of the palette error-diffusion ditherer: control, error rows and palette.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | op, entry_index, rgb, tap fields, enable
//  m_      | out       | m_valid / m_ready   | color_index, out rgb, last_pixel
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_addr, cfg_wdata
//
// A load op is taken in the idle state; a pixel's time grows with palette_count and
// with each applied tap, which waits on the bit-serial error dividers, while a skipped
// tap only advances the tap index; the palette is read one entry a cycle.
// After reset a clearing pass writes zero to all MAX_WIDTH * (MAX_ROW_OFFSET + 1)
// error entries, one a cycle, with s_ready low.
// A result waits in the output register; a stalled m_ready holds only the next pixel.
module palette_error_diffusion_top
    import ped_pkg::*;
#(
    parameter int MAX_WIDTH       = 2048,
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_TAPS        = 16,
    parameter int MAX_ROW_OFFSET  = 2,
    parameter int ERROR_FRAC_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [7:0]        s_entry_index,
    input  logic [7:0]        s_red,
    input  logic [7:0]        s_green,
    input  logic [7:0]        s_blue,
    input  logic signed [4:0] s_tap_dx,
    input  logic [1:0]        s_tap_dy,
    input  logic signed [7:0] s_tap_weight,
    input  logic              s_diffuse_enable,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_color_index,
    output logic [7:0]        m_out_red,
    output logic [7:0]        m_out_green,
    output logic [7:0]        m_out_blue,
    output logic              m_last_pixel,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata
);

    localparam int F         = ERROR_FRAC_BITS;
    localparam int ROW_BANKS = MAX_ROW_OFFSET + 1;
    localparam int ERR_DEPTH = MAX_WIDTH * ROW_BANKS;
    localparam int AW        = $clog2(ERR_DEPTH);
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int CW        = $clog2(MAX_WIDTH + 1);
    localparam int EW        = (CW > 12) ? CW : 12;
    localparam int BW        = $clog2(ROW_BANKS);
    localparam int PIW       = $clog2(PALETTE_ENTRIES);
    localparam int NPW       = $clog2(PALETTE_ENTRIES + 1);
    localparam int TIW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW       = $clog2(MAX_TAPS + 1);
    localparam int VW        = (((8 + F) > 23) ? (8 + F) : 23) + 2;
    localparam int PW        = VW + 24;
    localparam int QW        = VW + 14;
    localparam int NXW       = XW + 2;
    localparam int SMW       = QW + 2;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_POS  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_LOAD = 4'd4;
    localparam logic [3:0] S_SRCH = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;
    localparam logic [3:0] S_TSET = 4'd7;
    localparam logic [3:0] S_TMUL = 4'd8;
    localparam logic [3:0] S_TDIV = 4'd9;
    localparam logic [3:0] S_TWR  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0] state_reg, state_next;

    // configuration
    logic [11:0] width_cfg_reg;
    logic [15:0] height_cfg_reg;
    logic [8:0]  palcnt_cfg_reg;
    logic [4:0]  tapcnt_cfg_reg;
    logic [15:0] divisor_cfg_reg;
    logic [15:0] strength_cfg_reg;
    logic        serp_cfg_reg;

    logic [CW-1:0]  wc;
    logic [15:0]    hc;
    logic [NPW-1:0] np;
    logic [TCW-1:0] nt;
    logic [15:0]    dvc;

    // position
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic [BW-1:0] bank_reg;
    logic [CW-1:0] col_f;
    logic [16:0]   row1;
    logic [15:0]   row_f;
    logic [BW-1:0] bank1, bank_f;
    logic          wrap_col;
    logic          rev_f;
    logic [CW-1:0] x_f;
    logic [XW-1:0] x_reg;
    logic          rev_reg;
    logic [AW-1:0] slot_reg;
    logic          last_reg;

    // pixel
    logic [7:0]           pix_reg [3];
    logic                 den_reg;
    logic signed [VW-1:0] v_reg [3];
    logic signed [VW-1:0] diff_reg [3];
    logic signed [PW-1:0] prod_reg [3];

    // error memory
    logic                 err_we, err_re;
    logic [AW-1:0]        err_waddr, err_raddr;
    logic [3*ERR_W-1:0]   err_wdata, err_rdata;
    logic [AW-1:0]        clr_reg;
    logic signed [ERR_W-1:0] err_lane [3];
    logic signed [ERR_W-1:0] sat_lane [3];

    // palette
    logic           pal_we, pal_re;
    logic [PIW-1:0] pal_waddr, pal_raddr;
    rgb_t           pal_rdata;
    logic [NPW-1:0] issue_reg;
    logic           s1_valid_reg;
    logic [7:0]     s1_idx_reg;
    near_res_t      near_res;

    // taps
    logic signed [4:0] tap_dx_reg [MAX_TAPS];
    logic [1:0]        tap_dy_reg [MAX_TAPS];
    logic signed [7:0] tap_wt_reg [MAX_TAPS];
    logic [TCW-1:0]    tap_idx_reg;
    logic [TIW-1:0]    ti;
    logic signed [4:0] t_dx;
    logic [1:0]        t_dy;
    logic signed [7:0] t_wt;
    logic signed [NXW-1:0] nx;
    logic signed [NXW-1:0] xe, dxe;
    logic [16:0]       ny;
    logic [BW+1:0]     nb_sum, nb_fix;
    logic              t_skip;
    logic [AW-1:0]     ns_reg;
    logic signed [23:0] scale_reg;
    logic               div_go_reg;
    logic [2:0]         div_busy;
    logic [QW-1:0]      quo [3];
    logic               tap_last;

    // output
    logic       m_valid_reg;
    logic [7:0] m_idx_reg;
    rgb_t       m_color_reg;
    logic       m_last_reg;
    logic       out_load;

    logic s_xfer;

    assign s_xfer    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // clamped configuration
    always_comb begin
        if (width_cfg_reg == 12'd0) begin
            wc = CW'(1);
        end else if (EW'(width_cfg_reg) > EW'(MAX_WIDTH)) begin
            wc = CW'(MAX_WIDTH);
        end else begin
            wc = CW'(width_cfg_reg);
        end
        hc = (height_cfg_reg == 16'd0) ? 16'd1 : height_cfg_reg;
        if (palcnt_cfg_reg == 9'd0) begin
            np = NPW'(1);
        end else if (palcnt_cfg_reg > 9'(PALETTE_ENTRIES)) begin
            np = NPW'(PALETTE_ENTRIES);
        end else begin
            np = NPW'(palcnt_cfg_reg);
        end
        nt  = (6'(tapcnt_cfg_reg) > 6'(MAX_TAPS)) ? TCW'(MAX_TAPS) : TCW'(tapcnt_cfg_reg);
        dvc = (divisor_cfg_reg == 16'd0) ? 16'd1 : divisor_cfg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg    <= 12'd640;
            height_cfg_reg   <= 16'd480;
            palcnt_cfg_reg   <= 9'd2;
            tapcnt_cfg_reg   <= 5'd4;
            divisor_cfg_reg  <= 16'd16;
            strength_cfg_reg <= 16'd256;
            serp_cfg_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_cfg_reg    <= cfg_wdata[11:0];
                REG_IMAGE_HEIGHT: height_cfg_reg   <= cfg_wdata;
                REG_PAL_COUNT:    palcnt_cfg_reg   <= cfg_wdata[8:0];
                REG_TAP_COUNT:    tapcnt_cfg_reg   <= cfg_wdata[4:0];
                REG_ERR_DIVISOR:  divisor_cfg_reg  <= cfg_wdata;
                REG_STRENGTH:     strength_cfg_reg <= cfg_wdata;
                REG_SERPENTINE:   serp_cfg_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // position fix-up ahead of each pixel
    always_comb begin
        wrap_col = (col_reg >= wc);
        col_f    = wrap_col ? '0 : col_reg;
        row1     = wrap_col ? 17'(row_reg) + 17'd1 : 17'(row_reg);
        bank1    = bank_reg;
        if (wrap_col) begin
            bank1 = (bank_reg == BW'(ROW_BANKS - 1)) ? '0 : bank_reg + BW'(1);
        end
        row_f  = (row1 >= 17'(hc)) ? 16'd0 : row1[15:0];
        bank_f = (row1 >= 17'(hc)) ? '0 : bank1;
        rev_f  = serp_cfg_reg && row_f[0];
        x_f    = rev_f ? wc - CW'(1) - col_f : col_f;
    end

    // tap decode
    assign ti   = TIW'(tap_idx_reg);
    assign t_dx = tap_dx_reg[ti];
    assign t_dy = tap_dy_reg[ti];
    assign t_wt = tap_wt_reg[ti];
    assign xe   = $signed({2'b00, x_reg});
    assign dxe  = NXW'(t_dx);
    assign nx   = rev_reg ? xe - dxe : xe + dxe;
    assign ny   = 17'(row_reg) + 17'(t_dy);

    always_comb begin
        nb_sum = (BW+2)'(bank_reg) + (BW+2)'(t_dy);
        nb_fix = (nb_sum >= (BW+2)'(ROW_BANKS)) ? nb_sum - (BW+2)'(ROW_BANKS) : nb_sum;
        t_skip = (t_dy == 2'd0 && t_dx <= 5'sd0)
              || (3'(t_dy) > 3'(MAX_ROW_OFFSET))
              || (nx < 0)
              || (nx >= $signed(NXW'(wc)))
              || (ny >= 17'(hc));
    end

    assign tap_last = (tap_idx_reg + TCW'(1) >= nt);

    // error lanes: red in the top bits
    genvar gl;
    generate
        for (gl = 0; gl < 3; gl++) begin : g_lane
            logic signed [QW:0]    q_s;
            logic signed [SMW-1:0] sum;
            logic [PW-1:0]         mag;

            assign err_lane[gl] = err_rdata[(2-gl)*ERR_W +: ERR_W];
            assign mag = prod_reg[gl][PW-1] ? PW'(-prod_reg[gl]) : PW'(prod_reg[gl]);
            assign q_s = prod_reg[gl][PW-1] ? -$signed({1'b0, quo[gl]})
                                            : $signed({1'b0, quo[gl]});
            assign sum = SMW'(err_lane[gl]) + SMW'(q_s);

            always_comb begin
                if (sum > SMW'(24'sh7FFFFF)) begin
                    sat_lane[gl] = 24'sh7FFFFF;
                end else if (sum < -SMW'(24'sh7FFFFF) - SMW'(1)) begin
                    sat_lane[gl] = 24'sh800000;
                end else begin
                    sat_lane[gl] = ERR_W'(sum);
                end
            end

            ped_div #(.QW(QW)) u_div (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .start    (div_go_reg),
                .dividend (mag[VW+21:8]),
                .divisor  (dvc),
                .busy     (div_busy[gl]),
                .quotient (quo[gl])
            );
        end
    endgenerate

    // error memory ports
    always_comb begin
        err_we    = 1'b0;
        err_waddr = slot_reg;
        err_wdata = '0;
        err_re    = 1'b0;
        err_raddr = slot_reg;
        case (state_reg)
            S_CLR: begin
                err_we    = 1'b1;
                err_waddr = clr_reg;
            end
            S_RD: err_re = 1'b1;
            S_LOAD: err_we = 1'b1;
            S_TMUL: begin
                err_re    = 1'b1;
                err_raddr = ns_reg;
            end
            S_TWR: begin
                err_we    = 1'b1;
                err_waddr = ns_reg;
                err_wdata = {sat_lane[0], sat_lane[1], sat_lane[2]};
            end
            default: ;
        endcase
    end

    ped_ram #(.DEPTH(ERR_DEPTH), .WIDTH(3 * ERR_W)) u_err_ram (
        .aclk  (aclk),
        .we    (err_we),
        .waddr (err_waddr),
        .wdata (err_wdata),
        .re    (err_re),
        .raddr (err_raddr),
        .rdata (err_rdata)
    );

    // palette memory
    assign pal_we    = s_xfer && (s_op == OP_PALETTE) && (9'(s_entry_index) < 9'(PALETTE_ENTRIES));
    assign pal_waddr = PIW'(s_entry_index);
    assign pal_re    = (state_reg == S_SRCH) && (issue_reg < np);
    assign pal_raddr = PIW'(issue_reg);

    ped_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(24)) u_pal_ram (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata ({s_red, s_green, s_blue}),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    ped_near #(.VW(VW), .F(F)) u_near (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_idx   (s1_idx_reg),
        .in_color (pal_rdata),
        .v_r      (v_reg[0]),
        .v_g      (v_reg[1]),
        .v_b      (v_reg[2]),
        .res      (near_res)
    );

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_reg == AW'(ERR_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE: if (s_xfer && s_op == OP_PIXEL) state_next = S_POS;
            S_POS:  state_next = S_RD;
            S_RD:   state_next = S_LOAD;
            S_LOAD: state_next = S_SRCH;
            S_SRCH: begin
                if (issue_reg >= np && !s1_valid_reg && !near_res.busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = (den_reg && nt != '0) ? S_TSET : S_DONE;
                end
            end
            S_TSET: begin
                if (!t_skip) begin
                    state_next = S_TMUL;
                end else if (tap_last) begin
                    state_next = S_DONE;
                end
            end
            S_TMUL: state_next = S_TDIV;
            S_TDIV: if (!div_go_reg && !div_busy[0]) state_next = S_TWR;
            S_TWR:  state_next = tap_last ? S_DONE : S_TSET;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            bank_reg     <= '0;
            s1_valid_reg <= 1'b0;
            div_go_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            issue_reg    <= '0;
            tap_idx_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= pal_re;
            div_go_reg   <= (state_reg == S_TMUL);
            if (state_reg == S_CLR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == S_POS) begin
                col_reg  <= col_f;
                row_reg  <= row_f;
                bank_reg <= bank_f;
            end
            if (state_reg == S_DONE) begin
                if (last_reg) begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    bank_reg <= '0;
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (state_reg == S_LOAD) begin
                issue_reg <= '0;
            end else if (pal_re) begin
                issue_reg <= issue_reg + NPW'(1);
            end
            if (state_reg == S_OUT) begin
                tap_idx_reg <= '0;
            end else if ((state_reg == S_TSET && t_skip) || state_reg == S_TWR) begin
                tap_idx_reg <= tap_idx_reg + TCW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        s1_idx_reg <= 8'(issue_reg);
        if (s_xfer && s_op == OP_TAP && 9'(s_entry_index) < 9'(MAX_TAPS)) begin
            tap_dx_reg[TIW'(s_entry_index)] <= s_tap_dx;
            tap_dy_reg[TIW'(s_entry_index)] <= s_tap_dy;
            tap_wt_reg[TIW'(s_entry_index)] <= s_tap_weight;
        end
        if (s_xfer && s_op == OP_PIXEL) begin
            pix_reg[0] <= s_red;
            pix_reg[1] <= s_green;
            pix_reg[2] <= s_blue;
            den_reg    <= s_diffuse_enable;
        end
        if (state_reg == S_POS) begin
            x_reg    <= XW'(x_f);
            rev_reg  <= rev_f;
            slot_reg <= AW'(bank_f * MAX_WIDTH) + AW'(x_f);
            last_reg <= (col_f == wc - CW'(1)) && (row_f == hc - 16'd1);
        end
        if (state_reg == S_LOAD) begin
            for (int c = 0; c < 3; c++) begin
                v_reg[c] <= $signed({{(VW-8-F){1'b0}}, pix_reg[c], {F{1'b0}}})
                          + VW'(err_lane[c]);
            end
        end
        if (out_load) begin
            m_idx_reg   <= near_res.idx;
            m_color_reg <= near_res.color;
            m_last_reg  <= last_reg;
            diff_reg[0] <= v_reg[0] - $signed({{(VW-8-F){1'b0}}, near_res.color.r, {F{1'b0}}});
            diff_reg[1] <= v_reg[1] - $signed({{(VW-8-F){1'b0}}, near_res.color.g, {F{1'b0}}});
            diff_reg[2] <= v_reg[2] - $signed({{(VW-8-F){1'b0}}, near_res.color.b, {F{1'b0}}});
        end
        if (state_reg == S_TSET) begin
            ns_reg    <= AW'(nb_fix * MAX_WIDTH) + AW'(nx[XW-1:0]);
            scale_reg <= 24'($signed({1'b0, strength_cfg_reg})) * 24'(t_wt);
        end
        if (state_reg == S_TMUL) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[c] <= PW'(diff_reg[c]) * PW'(scale_reg);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_color_index = m_idx_reg;
    assign m_out_red     = m_color_reg.r;
    assign m_out_green   = m_color_reg.g;
    assign m_out_blue    = m_color_reg.b;
    assign m_last_pixel  = m_last_reg;

    a_twr_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TWR) |-> (div_busy == 3'b000))
        else $error("error writeback before divide finished");

    a_idle_no_err_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !err_we)
        else $error("error memory written while idle");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output step");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH) |-> (issue_reg <= np))
        else $error("palette read past entry count");

endmodule
